FILE: rtl/chol_pkg.sv
// ----------------------------------------------------------------------------
// chol_pkg
// Shared widths and saturation limits for the Cholesky factorization core.
// ----------------------------------------------------------------------------
package chol_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned CFG_W  = 4;
  localparam int unsigned ACC_W  = 64;

  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

FILE: rtl/cholesky_decomposition_core.sv
// ----------------------------------------------------------------------------
// cholesky_decomposition_core
// Fixed-point Cholesky factor of a symmetric matrix, one shared datapath.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o, entry_value_i): lower-triangle entries
// of the matrix, row-major, one per transfer, one per cycle while loading.
// Output channel (out_valid_o/out_ready_i): factor entries row-major, with
// row/column, a last flag on the final entry and pivot_clamped/zero_divisor.
// cfg_we_i/cfg_wdata_i sets the matrix order (0 acts as 1, above MAX_ORDER
// as MAX_ORDER) and restarts loading; write it only while idle.
// Once the final entry is taken the core stops accepting input and computes
// each factor entry in turn: setup (S_START, S_INIT), then each inner product
// term through the one multiplier (S_FETCH, S_MUL, S_ACC), then for a
// diagonal entry a 31-step square root and for an off-diagonal entry a pivot
// read plus a 31-step restoring division, one bit per cycle, unless the
// result saturates or is flagged. Each result waits in the output register
// until taken; a stalled receiver simply holds the sequencer. After the last
// result the core returns to loading.
// Reset (rst_ni low, asynchronous) sets order MAX_ORDER, empties the load
// count and leaves the output channel idle; the stores are not cleared.
// ----------------------------------------------------------------------------
module cholesky_decomposition_core #(
  parameter int unsigned MAX_ORDER = 8,
  parameter int unsigned FRAC_BITS = 28
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [chol_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [chol_pkg::DATA_W-1:0]  entry_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [chol_pkg::DATA_W-1:0]  factor_value_o,
  output logic [chol_pkg::IDX_W-1:0]          row_index_o,
  output logic [chol_pkg::IDX_W-1:0]          col_index_o,
  output logic                                last_of_run_o,
  output logic                                pivot_clamped_o,
  output logic                                zero_divisor_o
);

  localparam int unsigned DW    = chol_pkg::DATA_W;
  localparam int unsigned XW    = chol_pkg::ACC_W;
  localparam int unsigned DEPTH = MAX_ORDER * (MAX_ORDER + 1) / 2;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned IW    = $clog2(MAX_ORDER);
  localparam int unsigned NW    = $clog2(MAX_ORDER + 1);
  localparam int unsigned STEPS = 31;
  localparam int unsigned SW    = $clog2(STEPS);
  localparam int unsigned CFG_W_L = chol_pkg::CFG_W;

  localparam logic [XW-1:0] ROOT_LIM  = XW'(1) << (62 - FRAC_BITS);
  localparam logic [XW-1:0] ROUND_ADD = XW'(1) << (FRAC_BITS - 1);
  localparam logic [XW-1:0] BIT_INIT  = XW'(1) << 60;

  typedef enum logic [3:0] {
    S_LOAD, S_START, S_INIT, S_FETCH, S_MUL, S_ACC,
    S_FIN, S_PIV, S_SQRT, S_DIV, S_OUT
  } state_e;

  function automatic logic [AW-1:0] tri_addr(input logic [IW-1:0] ii,
                                             input logic [IW-1:0] jj);
    logic [AW:0] base;
    base = ((AW+1)'(ii) * ((AW+1)'(ii) + 1'b1)) >> 1;
    return AW'(base + (AW+1)'(jj));
  endfunction

  state_e                state_q;
  logic [CFG_W_L-1:0]    order_q;
  logic [CW-1:0]         load_q;
  logic [IW-1:0]         i_q, j_q, k_q;
  logic signed [XW-1:0]  sum_q;
  logic signed [XW-1:0]  prod_q;
  logic [XW-1:0]         acc_q, aux_q, bit_q;
  logic [SW-1:0]         step_q;
  logic                  neg_q;
  logic [DW-1:0]         val_q;
  logic                  out_valid_q, last_q, clamp_q, zdiv_q;

  logic [NW-1:0] n_eff;
  logic [CW-1:0] total;
  logic [IW-1:0] n_last;

  always_comb begin
    priority if (order_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(order_q) > MAX_ORDER) begin
      n_eff = NW'(MAX_ORDER);
    end else begin
      n_eff = NW'(order_q);
    end
    total  = CW'(((CW+NW)'(n_eff) * ((CW+NW)'(n_eff) + 1'b1)) >> 1);
    n_last = IW'(n_eff - 1'b1);
  end

  // memories
  logic [DW-1:0] in_mem [DEPTH];
  logic [DW-1:0] f_mem  [DEPTH];
  logic [DW-1:0] in_rd_q, f_rd0_q, f_rd1_q;
  logic [AW-1:0] fa0, fa1, ia;
  logic          in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && (state_q == S_LOAD);
  assign out_xfer = out_valid_q && out_ready_i;
  assign ia  = tri_addr(i_q, j_q);
  assign fa0 = (state_q == S_FIN) ? tri_addr(j_q, j_q) : tri_addr(i_q, k_q);
  assign fa1 = tri_addr(j_q, k_q);

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_mem[load_q[AW-1:0]] <= entry_value_i;
    end
    in_rd_q <= in_mem[ia];
  end

  always_ff @(posedge clk_i) begin
    if (out_xfer) begin
      f_mem[ia] <= val_q;
    end
    f_rd0_q <= f_mem[fa0];
    f_rd1_q <= f_mem[fa1];
  end

  // datapath helpers
  logic [XW-1:0] mag, rb_sum, div_lim, shifted;
  logic signed [XW-1:0] rounded;

  always_comb begin
    mag     = sum_q[XW-1] ? XW'(-sum_q) : XW'(sum_q);
    rb_sum  = aux_q + bit_q;
    div_lim = {{(XW-DW){1'b0}}, f_rd0_q} << (31 - FRAC_BITS);
    shifted = mag << FRAC_BITS;
    rounded = (prod_q + $signed(ROUND_ADD)) >>> FRAC_BITS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      order_q     <= CFG_W_L'(MAX_ORDER);
      load_q      <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      clamp_q     <= 1'b0;
      zdiv_q      <= 1'b0;
      step_q      <= '0;
      neg_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        order_q <= cfg_wdata_i;
      end
      unique case (state_q)
        S_LOAD: begin
          if (cfg_we_i) begin
            load_q <= '0;
          end else if (in_xfer) begin
            if (load_q + 1'b1 >= total) begin
              load_q  <= '0;
              i_q     <= '0;
              j_q     <= '0;
              k_q     <= '0;
              state_q <= S_START;
            end else begin
              load_q <= load_q + 1'b1;
            end
          end
        end
        S_START: begin
          state_q <= S_INIT;
        end
        S_INIT: begin
          sum_q   <= {{(XW-DW){in_rd_q[DW-1]}}, in_rd_q};
          state_q <= (j_q == '0) ? S_FIN : S_MUL;
        end
        S_FETCH: begin
          state_q <= S_MUL;
        end
        S_MUL: begin
          prod_q  <= $signed(f_rd0_q) * $signed(f_rd1_q);
          state_q <= S_ACC;
        end
        S_ACC: begin
          sum_q <= sum_q - rounded;
          k_q   <= k_q + 1'b1;
          if ((IW+1)'(k_q) + 1'b1 == (IW+1)'(j_q)) begin
            state_q <= S_FIN;
          end else begin
            state_q <= S_FETCH;
          end
        end
        S_FIN: begin
          clamp_q <= 1'b0;
          zdiv_q  <= 1'b0;
          last_q  <= (i_q == n_last) && (j_q == i_q);
          if (i_q == j_q) begin
            priority if (sum_q < 0) begin
              clamp_q     <= 1'b1;
              val_q       <= '0;
              out_valid_q <= 1'b1;
              state_q     <= S_OUT;
            end else if (XW'(sum_q) >= ROOT_LIM) begin
              val_q       <= chol_pkg::SAT_MAX;
              out_valid_q <= 1'b1;
              state_q     <= S_OUT;
            end else begin
              acc_q   <= XW'(sum_q) << FRAC_BITS;
              aux_q   <= '0;
              bit_q   <= BIT_INIT;
              step_q  <= '0;
              state_q <= S_SQRT;
            end
          end else begin
            state_q <= S_PIV;
          end
        end
        S_PIV: begin
          neg_q <= sum_q[XW-1];
          priority if (f_rd0_q[DW-1] || f_rd0_q == '0) begin
            zdiv_q      <= 1'b1;
            val_q       <= '0;
            out_valid_q <= 1'b1;
            state_q     <= S_OUT;
          end else if (mag >= div_lim) begin
            val_q       <= sum_q[XW-1] ? chol_pkg::SAT_MIN : chol_pkg::SAT_MAX;
            out_valid_q <= 1'b1;
            state_q     <= S_OUT;
          end else begin
            acc_q   <= shifted;
            aux_q   <= '0;
            bit_q   <= {{(XW-DW){1'b0}}, f_rd0_q} << 30;
            step_q  <= '0;
            state_q <= S_DIV;
          end
        end
        S_SQRT: begin
          if (acc_q >= rb_sum) begin
            acc_q <= acc_q - rb_sum;
            aux_q <= (aux_q >> 1) + bit_q;
          end else begin
            aux_q <= aux_q >> 1;
          end
          bit_q  <= bit_q >> 2;
          step_q <= step_q + 1'b1;
          if (32'(step_q) == STEPS - 1) begin
            state_q <= S_OUT;
          end
        end
        S_DIV: begin
          if (acc_q >= bit_q) begin
            acc_q <= acc_q - bit_q;
            aux_q <= {aux_q[XW-2:0], 1'b1};
          end else begin
            aux_q <= {aux_q[XW-2:0], 1'b0};
          end
          bit_q  <= bit_q >> 1;
          step_q <= step_q + 1'b1;
          if (32'(step_q) == STEPS - 1) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
            if (j_q == i_q) begin
              val_q <= DW'(aux_q);
            end else begin
              val_q <= neg_q ? DW'(-aux_q) : DW'(aux_q);
            end
          end else if (out_ready_i) begin
            out_valid_q <= 1'b0;
            k_q         <= '0;
            if (j_q == i_q) begin
              if (i_q == n_last) begin
                state_q <= S_LOAD;
              end else begin
                i_q     <= i_q + 1'b1;
                j_q     <= '0;
                state_q <= S_START;
              end
            end else begin
              j_q     <= j_q + 1'b1;
              state_q <= S_START;
            end
          end
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

  assign in_ready_o      = (state_q == S_LOAD);
  assign out_valid_o     = out_valid_q;
  assign factor_value_o  = val_q;
  assign row_index_o     = chol_pkg::IDX_W'(i_q);
  assign col_index_o     = chol_pkg::IDX_W'(j_q);
  assign last_of_run_o   = last_q;
  assign pivot_clamped_o = clamp_q;
  assign zero_divisor_o  = zdiv_q;

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - Cholesky factorization core testbench
// Loads lower-triangle matrices through a valid/ready channel, predicts every
// factor entry with a fixed-point model of its own, and checks each output
// transfer field by field. Directed corner matrices come first, then random
// positive-definite and noise matrices over many matrix orders, with random
// gaps on both channels, a long receiver hold-off and drains between phases.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ORDER_MAX = 8;
  localparam int FRAC      = 28;
  localparam int TRI_DEPTH = ORDER_MAX * (ORDER_MAX + 1) / 2;

  typedef struct packed {
    logic [chol_pkg::DATA_W-1:0] value;
    logic [chol_pkg::IDX_W-1:0]  row;
    logic [chol_pkg::IDX_W-1:0]  col;
    logic                        last;
    logic                        clamped;
    logic                        zdiv;
  } factor_t;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               cfg_we_i;
  logic [chol_pkg::CFG_W-1:0]         cfg_wdata_i;
  logic                               in_valid_i;
  logic                               in_ready_o;
  logic signed [chol_pkg::DATA_W-1:0] entry_value_i;
  logic                               out_valid_o;
  logic                               out_ready_i;
  logic signed [chol_pkg::DATA_W-1:0] factor_value_o;
  logic [chol_pkg::IDX_W-1:0]         row_index_o;
  logic [chol_pkg::IDX_W-1:0]         col_index_o;
  logic                               last_of_run_o;
  logic                               pivot_clamped_o;
  logic                               zero_divisor_o;

  cholesky_decomposition_core #(
    .MAX_ORDER (ORDER_MAX),
    .FRAC_BITS (FRAC)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .entry_value_i   (entry_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .factor_value_o  (factor_value_o),
    .row_index_o     (row_index_o),
    .col_index_o     (col_index_o),
    .last_of_run_o   (last_of_run_o),
    .pivot_clamped_o (pivot_clamped_o),
    .zero_divisor_o  (zero_divisor_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // model state
  logic [chol_pkg::CFG_W-1:0]  order_reg;
  logic [chol_pkg::DATA_W-1:0] entry_mem [TRI_DEPTH];
  logic [chol_pkg::DATA_W-1:0] factor_mem [TRI_DEPTH];
  int                          load_cnt;

  logic [chol_pkg::DATA_W-1:0] entry_q [$];
  factor_t                     factor_q [$];
  int                          mismatches;
  int                          n_results;
  int                          n_clamped;
  int                          n_zdiv;
  int                          n_runs;
  int                          n_items;
  bit                          idle_on;
  int                          hold_req;
  bit                          in_taken;
  bit                          out_taken;

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [chol_pkg::DATA_W-1:0] pivot_root(longint sum);
    longint unsigned r;
    if (longint'(sum) >= (longint'(1) << (62 - FRAC))) return chol_pkg::SAT_MAX;
    r = isqrt(longint'(sum) << FRAC);
    if (r > 64'h7fff_ffff) return chol_pkg::SAT_MAX;
    return r[chol_pkg::DATA_W-1:0];
  endfunction

  function automatic logic [chol_pkg::DATA_W-1:0] scaled_quotient(longint sum,
                                                                  longint unsigned d);
    bit              neg;
    longint unsigned mag;
    longint unsigned qi;
    longint unsigned rem;
    longint unsigned q;
    neg = sum < 0;
    mag = neg ? longint'(-sum) : longint'(sum);
    qi  = mag / d;
    rem = mag % d;
    if (qi >= (64'd1 << (31 - FRAC))) return neg ? chol_pkg::SAT_MIN : chol_pkg::SAT_MAX;
    q = (qi << FRAC) + ((rem << FRAC) / d);
    if (neg) q = -q;
    return q[chol_pkg::DATA_W-1:0];
  endfunction

  function automatic int tri_idx(int i, int j);
    return i * (i + 1) / 2 + j;
  endfunction

  function automatic int eff_order();
    if (order_reg == 0) return 1;
    if (order_reg > ORDER_MAX) return ORDER_MAX;
    return order_reg;
  endfunction

  function automatic void factor_predict(logic [chol_pkg::DATA_W-1:0] entry);
    int      n;
    longint  sum;
    longint  p;
    longint  pivot;
    factor_t f;
    n = eff_order();
    if (load_cnt >= TRI_DEPTH) load_cnt = 0;
    entry_mem[load_cnt] = entry;
    load_cnt++;
    if (load_cnt < n * (n + 1) / 2) return;
    load_cnt = 0;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j <= i; j++) begin
        sum = longint'($signed(entry_mem[tri_idx(i, j)]));
        for (int k = 0; k < j; k++) begin
          p = longint'($signed(factor_mem[tri_idx(i, k)])) *
              longint'($signed(factor_mem[tri_idx(j, k)]));
          sum = sum - ((p + (longint'(1) << (FRAC - 1))) >>> FRAC);
        end
        f = '0;
        if (i == j) begin
          if (sum < 0) begin
            sum = 0;
            f.clamped = 1'b1;
          end
          f.value = pivot_root(sum);
        end else begin
          pivot = longint'($signed(factor_mem[tri_idx(j, j)]));
          if (pivot <= 0) begin
            f.value = '0;
            f.zdiv  = 1'b1;
          end else begin
            f.value = scaled_quotient(sum, pivot);
          end
        end
        factor_mem[tri_idx(i, j)] = f.value;
        f.row  = i[chol_pkg::IDX_W-1:0];
        f.col  = j[chol_pkg::IDX_W-1:0];
        f.last = (i == n - 1) && (j == i);
        factor_q.insert(factor_q.size(), f);
      end
    end
  endfunction

  // sender
  always @(negedge clk_i) begin
    static int gap_cnt = 0;
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      entry_value_i <= '0;
    end else if (!(in_valid_i && !in_taken)) begin
      if (in_taken) gap_cnt = (idle_on && $urandom_range(0, 1)) ? $urandom_range(0, 17) : 0;
      if (gap_cnt > 0) begin
        gap_cnt--;
        in_valid_i <= 1'b0;
      end else if (entry_q.size() > 0) begin
        in_valid_i    <= 1'b1;
        entry_value_i <= entry_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    static int stall_cnt = 0;
    static int hold_cnt = 0;
    if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (out_taken) stall_cnt = (idle_on && $urandom_range(0, 1)) ? $urandom_range(0, 17) : 0;
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready_i <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    factor_t got;
    factor_t exp_f;
    in_taken  <= rst_ni && in_valid_i && in_ready_o;
    out_taken <= rst_ni && out_valid_o && out_ready_i;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) factor_predict(entry_value_i);
      if (out_valid_o && out_ready_i) begin
        got = '{factor_value_o, row_index_o, col_index_o, last_of_run_o,
                pivot_clamped_o, zero_divisor_o};
        n_results++;
        if (got.clamped) n_clamped++;
        if (got.zdiv) n_zdiv++;
        if (got.last) n_runs++;
        if (factor_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected factor transfer: %p", got);
        end else begin
          exp_f = factor_q.pop_front();
          if (got !== exp_f) begin
            mismatches++;
            if (mismatches <= 10)
              $display("factor mismatch L[%0d][%0d]: exp %p got %p",
                       exp_f.row, exp_f.col, exp_f, got);
          end
        end
      end
    end
  end

  task automatic write_order(int val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val[chol_pkg::CFG_W-1:0];
    order_reg = val[chol_pkg::CFG_W-1:0];
    load_cnt  = 0;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (entry_q.size() > 0 || in_valid_i || factor_q.size() > 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic push_entry(int v);
    entry_q.insert(entry_q.size(), v);
    n_items++;
  endtask

  // diagonally dominant, hence positive definite
  task automatic push_spd(int n);
    for (int i = 0; i < n; i++)
      for (int j = 0; j <= i; j++)
        if (i == j) push_entry(n * (1 << 25) + $urandom_range(0, 1 << 26));
        else push_entry($signed($urandom_range(0, 1 << 26)) - (1 << 25));
  endtask

  task automatic push_noise(int n);
    for (int i = 0; i < n * (n + 1) / 2; i++) push_entry($urandom());
  endtask

  initial begin
    int n;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    entry_value_i = '0;
    out_ready_i = 1'b0;
    in_taken    = 1'b0;
    out_taken   = 1'b0;
    mismatches  = 0;
    n_results   = 0;
    n_clamped   = 0;
    n_zdiv      = 0;
    n_runs      = 0;
    n_items     = 0;
    idle_on     = 1'b0;
    hold_req    = 0;
    order_reg   = 4'd8;
    load_cnt    = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // order 1: extremes and a negative pivot
    write_order(1);
    push_entry(32'h7fff_ffff);
    push_entry(32'h8000_0000);
    push_entry(0);
    push_entry(1);
    drain();

    // order 2: zero pivot, quotient overflow both ways, exact cancel, clamp
    write_order(2);
    push_entry(0);       push_entry(5);            push_entry(1);
    push_entry(1);       push_entry(32'h7fff_ffff); push_entry(0);
    push_entry(1);       push_entry(32'h8000_0000); push_entry(0);
    push_entry(1 << 28); push_entry(1 << 28);      push_entry(1 << 28);
    push_entry(1 << 28); push_entry(32'h7fff_ffff); push_entry(0);
    drain();

    // order values out of range
    write_order(0);
    push_spd(1);
    drain();
    write_order(15);
    push_spd(8);
    drain();

    // long receiver hold while several matrices queue up
    idle_on = 1'b1;
    write_order(3);
    hold_req = 1500;
    repeat (4) push_spd(3);
    drain();

    while (n_items < 190) begin
      write_order($urandom_range(0, 15));
      n = eff_order();
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 99) < 80) push_spd(n);
        else push_noise(n);
      end
      if ($urandom_range(0, 3) == 0) idle_on = !idle_on;
      drain();
    end
    write_order(8);
    push_spd(8);
    drain();

    $display("covered %0d entries, %0d matrices, %0d factor entries",
             n_items, n_runs, n_results);
    $display("flags seen: %0d clamped pivots, %0d zero divisors", n_clamped, n_zdiv);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("mismatch count: %0d", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
